// File: rtl/lmq_pkg.sv
package lmq_pkg;

   // word field widths
   localparam int DATA_W  = 64;
   localparam int LEN_W   = 8;
   localparam int COUNT_W = 4;
   localparam int STAT_W  = 2;
   localparam int MSG_W   = 4;
   localparam int CAP_W   = 6;
   localparam int CSR_W   = 6;
   localparam int BYTES   = DATA_W / 8;

   // result status codes
   localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
   localparam logic [STAT_W-1:0] ST_EMPTY = 2'd1;
   localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;

   // request kinds
   localparam logic ACT_SEND = 1'b0;
   localparam logic ACT_RECV = 1'b1;

   // register indexes
   localparam logic CSR_MESSAGE_BYTES = 1'b0;
   localparam logic CSR_CAPACITY      = 1'b1;

   // register reset values
   localparam logic [MSG_W-1:0] MESSAGE_BYTES_RESET = 4'd8;
   localparam int               CAPACITY_RESET      = 32;

   // controller to datapath
   typedef struct packed {
      logic clear;    // zero one slot of the payload store
      logic accept;   // take the request word, start memory reads
      logic commit;   // update queue state, load the response word
   } lmq_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic clear_last;   // clearing sweep on its final slot
   } lmq_sts_type;

   // low n bytes set
   function automatic logic [DATA_W-1:0] byte_mask(input logic [COUNT_W-1:0] n);
      logic [DATA_W-1:0] m;
      m = '0;
      for (int b = 0; b < BYTES; b++) begin
         m[8*b +: 8] = (COUNT_W'(b) < n) ? 8'hFF : 8'h00;
      end
      return m;
   endfunction

endpackage

// File: rtl/linked_message_queue_unit.sv
// Linked message mailbox: SLOTS message slots of up to SLOT_BYTES bytes, queued
// as a linked FIFO with unused slots on a LIFO free list. A request word either
// sends (tuser 0) or receives (tuser 1); each request yields exactly one response
// word with a status, the clamped byte count and, for a receive, the payload.
// A request is handled in an accept step, which reads the link table and the
// payload store at the free top or queue head, then a commit step, which
// updates the lists and loads the response register, waiting while that
// register is still full. After reset the payload store is zeroed one slot per
// cycle, with req_tready held low until the sweep ends; register writes are taken
// at any time, and writing capacity empties the queue and rebuilds the free list.
module linked_message_queue_unit
   import lmq_pkg::*;
#(
   parameter int SLOTS      = 32,
   parameter int SLOT_BYTES = 8
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   input  logic [71:0]       req_tdata,   // payload_in[63:0], request_length[71:64]
   input  logic [0:0]        req_tuser,   // action[0]
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output logic [71:0]       rsp_tdata,   // byte_count[3:0], payload_out[67:4], zero
   output logic [1:0]        rsp_tuser,   // status[1:0]
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic              csr_index,
   input  logic [CSR_W-1:0]  csr_data
);

   lmq_cmd_type        cmd;
   lmq_sts_type        sts;
   logic [STAT_W-1:0]  rsp_status;
   logic [COUNT_W-1:0] rsp_count;
   logic [DATA_W-1:0]  rsp_payload;

   // register writes are always taken
   assign csr_ready = 1'b1;

   lmq_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   lmq_datapath #(
      .SLOTS      (SLOTS),
      .SLOT_BYTES (SLOT_BYTES)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .sts         (sts),
      .req_action  (req_tuser[0]),
      .req_payload (req_tdata[63:0]),
      .req_length  (req_tdata[71:64]),
      .csr_write   (csr_valid),
      .csr_index   (csr_index),
      .csr_data    (csr_data),
      .rsp_status  (rsp_status),
      .rsp_count   (rsp_count),
      .rsp_payload (rsp_payload)
   );

   assign rsp_tdata = {4'b0000, rsp_payload, rsp_count};
   assign rsp_tuser = rsp_status;

endmodule

// File: rtl/lmq_ram.sv
module lmq_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  logic                                   clock,
   input  logic                                   we,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
   input  logic [WIDTH-1:0]                       wdata,
   input  logic                                   re,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
   output logic [WIDTH-1:0]                       rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // one write port, one registered read port
   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

// File: rtl/lmq_ctrl.sv
module lmq_ctrl
   import lmq_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  lmq_sts_type sts,
   output lmq_cmd_type cmd
);

   localparam logic [1:0] S_CLEAR = 2'd0;
   localparam logic [1:0] S_IDLE  = 2'd1;
   localparam logic [1:0] S_EXEC  = 2'd2;

   logic [1:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;

   // sequencing: clear sweep, then accept / update per request
   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      case (state_ff)
         S_CLEAR: begin
            cmd.clear = 1'b1;
            if (sts.clear_last) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_tvalid) begin
               cmd.accept = 1'b1;
               state_in   = S_EXEC;
            end
         end
         S_EXEC: begin
            // wait for the response register to free up
            if (!rsp_valid_ff || rsp_tready) begin
               cmd.commit = 1'b1;
               state_in   = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // response word valid
   always_comb begin
      if (cmd.commit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;

endmodule

// File: rtl/lmq_datapath.sv
module lmq_datapath
   import lmq_pkg::*;
#(
   parameter int SLOTS      = 32,
   parameter int SLOT_BYTES = 8
) (
   input  logic              clock,
   input  logic              reset,
   input  lmq_cmd_type       cmd,
   output lmq_sts_type       sts,
   input  logic              req_action,
   input  logic [DATA_W-1:0] req_payload,
   input  logic [LEN_W-1:0]  req_length,
   input  logic              csr_write,
   input  logic              csr_index,
   input  logic [CSR_W-1:0]  csr_data,
   output logic [STAT_W-1:0] rsp_status,
   output logic [COUNT_W-1:0] rsp_count,
   output logic [DATA_W-1:0] rsp_payload
);

   localparam int IW      = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int CNTW    = $clog2(SLOTS + 1);
   localparam int RESET_N = (CAPACITY_RESET > SLOTS) ? SLOTS : CAPACITY_RESET;

   // configuration and queue state
   logic [MSG_W-1:0] msg_bytes_ff, msg_bytes_in;
   logic [IW-1:0]    head_ff, head_in;
   logic [IW-1:0]    tail_ff, tail_in;
   logic [IW-1:0]    free_top_ff, free_top_in;
   logic             free_valid_ff, free_valid_in;
   logic [CNTW-1:0]  count_ff, count_in;
   // slots below this mark still hold the rebuilt downward chain
   logic [CNTW-1:0]  fresh_ff, fresh_in;
   logic [IW-1:0]    clr_addr_ff, clr_addr_in;

   // request held over the memory read
   logic              action_ff;
   logic [DATA_W-1:0] data_ff;
   logic [COUNT_W-1:0] n_ff;
   logic [IW-1:0]     slot_ff;

   // response word
   logic [STAT_W-1:0]  status_ff, status_in;
   logic [COUNT_W-1:0] bcount_ff, bcount_in;
   logic [DATA_W-1:0]  payload_ff, payload_in;

   // memories
   logic              link_we;
   logic [IW-1:0]     link_waddr;
   logic [IW:0]       link_wdata;
   logic [IW:0]       link_rdata;
   logic              slot_we;
   logic [IW-1:0]     slot_waddr;
   logic [DATA_W-1:0] slot_wdata;
   logic [DATA_W-1:0] slot_rdata;
   logic [IW-1:0]     rd_addr;

   // misc
   logic [MSG_W-1:0]   size;
   logic [COUNT_W-1:0] n_req;
   logic [CNTW-1:0]    cap_n;
   logic               fresh;
   logic               next_valid;
   logic [IW-1:0]      next_idx;
   logic [DATA_W-1:0]  mask;

   // clamp the length to the slot size
   always_comb begin
      size  = (msg_bytes_ff > MSG_W'(SLOT_BYTES)) ? MSG_W'(SLOT_BYTES) : msg_bytes_ff;
      n_req = (req_length > LEN_W'(size)) ? COUNT_W'(size) : req_length[COUNT_W-1:0];
   end

   // send reads the free top, receive the head
   assign rd_addr = (req_action == ACT_RECV) ? head_ff : free_top_ff;

   // saturate a written capacity
   assign cap_n = (32'(csr_data) > 32'(SLOTS)) ? CNTW'(SLOTS) : CNTW'(csr_data);

   // successor of the popped free slot
   always_comb begin
      fresh = (CNTW'(slot_ff) < fresh_ff);
      if (fresh) begin
         next_valid = (slot_ff != '0);
         next_idx   = slot_ff - IW'(1);
      end else begin
         next_valid = link_rdata[IW];
         next_idx   = link_rdata[IW-1:0];
      end
      mask = byte_mask(n_ff);
   end

   // queue update and memory writes
   always_comb begin
      msg_bytes_in  = msg_bytes_ff;
      head_in       = head_ff;
      tail_in       = tail_ff;
      free_top_in   = free_top_ff;
      free_valid_in = free_valid_ff;
      count_in      = count_ff;
      fresh_in      = fresh_ff;
      clr_addr_in   = clr_addr_ff;
      status_in     = status_ff;
      bcount_in     = bcount_ff;
      payload_in    = payload_ff;
      link_we       = 1'b0;
      link_waddr    = tail_ff;
      link_wdata    = {1'b1, slot_ff};
      slot_we       = 1'b0;
      slot_waddr    = slot_ff;
      slot_wdata    = (slot_rdata & ~mask) | (data_ff & mask);

      // zero the payload store after reset
      if (cmd.clear) begin
         slot_we     = 1'b1;
         slot_waddr  = clr_addr_ff;
         slot_wdata  = '0;
         clr_addr_in = clr_addr_ff + IW'(1);
      end

      if (cmd.commit) begin
         status_in  = ST_OK;
         bcount_in  = n_ff;
         payload_in = '0;
         if (action_ff == ACT_SEND) begin
            if (!free_valid_ff) begin
               status_in = ST_FULL;
               bcount_in = '0;
            end else begin
               free_top_in   = next_idx;
               free_valid_in = next_valid;
               if (fresh) begin
                  fresh_in = CNTW'(slot_ff);
               end
               slot_we = 1'b1;
               // append behind the current tail
               if (count_ff != '0) begin
                  link_we = 1'b1;
               end else begin
                  head_in = slot_ff;
               end
               tail_in  = slot_ff;
               count_in = count_ff + CNTW'(1);
            end
         end else begin
            if (count_ff == '0) begin
               status_in = ST_EMPTY;
               bcount_in = '0;
            end else begin
               head_in       = link_rdata[IW-1:0];
               count_in      = count_ff - CNTW'(1);
               payload_in    = slot_rdata & mask;
               // push the slot back on the free list
               link_we       = 1'b1;
               link_waddr    = slot_ff;
               link_wdata    = {free_valid_ff, free_top_ff};
               free_top_in   = slot_ff;
               free_valid_in = 1'b1;
            end
         end
      end

      // register writes
      if (csr_write) begin
         if (csr_index == CSR_MESSAGE_BYTES) begin
            msg_bytes_in = csr_data[MSG_W-1:0];
         end else begin
            free_valid_in = (cap_n != '0);
            free_top_in   = IW'(cap_n - CNTW'(1));
            fresh_in      = cap_n;
            head_in       = '0;
            tail_in       = '0;
            count_in      = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         msg_bytes_ff  <= MESSAGE_BYTES_RESET;
         head_ff       <= '0;
         tail_ff       <= '0;
         free_top_ff   <= IW'(RESET_N - 1);
         free_valid_ff <= 1'b1;
         count_ff      <= '0;
         fresh_ff      <= CNTW'(RESET_N);
         clr_addr_ff   <= '0;
      end else begin
         msg_bytes_ff  <= msg_bytes_in;
         head_ff       <= head_in;
         tail_ff       <= tail_in;
         free_top_ff   <= free_top_in;
         free_valid_ff <= free_valid_in;
         count_ff      <= count_in;
         fresh_ff      <= fresh_in;
         clr_addr_ff   <= clr_addr_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         action_ff <= req_action;
         data_ff   <= req_payload;
         n_ff      <= n_req;
         slot_ff   <= rd_addr;
      end
      status_ff  <= status_in;
      bcount_ff  <= bcount_in;
      payload_ff <= payload_in;
   end

   lmq_ram #(
      .WIDTH (IW + 1),
      .DEPTH (SLOTS)
   ) u_link_ram (
      .clock (clock),
      .we    (link_we),
      .waddr (link_waddr),
      .wdata (link_wdata),
      .re    (cmd.accept),
      .raddr (rd_addr),
      .rdata (link_rdata)
   );

   lmq_ram #(
      .WIDTH (DATA_W),
      .DEPTH (SLOTS)
   ) u_slot_ram (
      .clock (clock),
      .we    (slot_we),
      .waddr (slot_waddr),
      .wdata (slot_wdata),
      .re    (cmd.accept),
      .raddr (rd_addr),
      .rdata (slot_rdata)
   );

   assign sts.clear_last = (clr_addr_ff == IW'(SLOTS - 1));
   assign rsp_status     = status_ff;
   assign rsp_count      = bcount_ff;
   assign rsp_payload    = payload_ff;

endmodule
